>>> rtl/rigid_body_euler_step_assert.svh
// ----------------------------------------------------------------------------
// rigid body euler step assertion macros
// concurrent checks on clk with rst_n as disable
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_EULER_STEP_ASSERT_SVH
`define RIGID_BODY_EULER_STEP_ASSERT_SVH

// same-cycle implication
`define RBE_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define RBE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// types, register map, reset values and micro-op sequence of the euler step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbe_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INV_MASS    = 3'd0,
        REG_GRAVITY_Y   = 3'd1,
        REG_GRAVITY_EN  = 3'd2,
        REG_DAMPING     = 3'd3,
        REG_RADIUS      = 3'd4,
        REG_WORLD_SIZE  = 3'd5,
        REG_INV_INERTIA = 3'd6
    } reg_index_t;

    localparam logic [30:0]        INV_MASS_RST    = 31'd4369;
    localparam logic signed [31:0] GRAVITY_Y_RST   = -32'sd65536;
    localparam logic               GRAVITY_EN_RST  = 1'b1;
    localparam logic [16:0]        DAMPING_RST     = 17'd64881;
    localparam logic [28:0]        RADIUS_RST      = 29'd983040;
    localparam logic [28:0]        WORLD_SIZE_RST  = 29'd268435456;
    localparam logic [30:0]        INV_INERTIA_RST = 31'd3;

    typedef struct packed {
        logic [30:0]        inv_mass;
        logic signed [31:0] gravity_y;
        logic               gravity_enable;
        logic [16:0]        damping;
        logic [28:0]        radius;
        logic [28:0]        world_size;
        logic [30:0]        inv_inertia;
    } cfg_t;

    typedef struct packed {
        logic [23:0]        dt;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
    } motion_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
    } pose_t;

    typedef enum logic [3:0] {
        OP_ACC_LIN,
        OP_ADD_VEL,
        OP_DAMP_VEL,
        OP_ADD_POS,
        OP_CLAMP,
        OP_ACC_ANG,
        OP_ADD_AVEL,
        OP_DAMP_AVEL,
        OP_ROT
    } op_t;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic SLOT_A = 1'b0;
    localparam logic SLOT_B = 1'b1;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic       slot;
    } micro_t;

    typedef struct packed {
        logic   capture;
        logic   issue;
        micro_t micro;
        logic   load_out;
    } ctrl_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } ctrl_state_t;

    localparam int SEQ_LEN = 26;
    localparam int STEP_W  = $clog2(SEQ_LEN);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SEQ_LEN - 1);

    // two independent chains interleaved so each op sees its predecessor's result
    function automatic micro_t seq_entry(input logic [STEP_W-1:0] step);
        micro_t m;
        case (step)
            5'd0:    m = '{OP_ACC_LIN,   AXIS_X, SLOT_A};
            5'd1:    m = '{OP_ACC_LIN,   AXIS_Z, SLOT_B};
            5'd2:    m = '{OP_ADD_VEL,   AXIS_X, SLOT_A};
            5'd3:    m = '{OP_ADD_VEL,   AXIS_Z, SLOT_B};
            5'd4:    m = '{OP_DAMP_VEL,  AXIS_X, SLOT_A};
            5'd5:    m = '{OP_DAMP_VEL,  AXIS_Z, SLOT_B};
            5'd6:    m = '{OP_ADD_POS,   AXIS_X, SLOT_A};
            5'd7:    m = '{OP_ADD_POS,   AXIS_Z, SLOT_B};
            5'd8:    m = '{OP_CLAMP,     AXIS_X, SLOT_A};
            5'd9:    m = '{OP_CLAMP,     AXIS_Z, SLOT_B};
            5'd10:   m = '{OP_ACC_LIN,   AXIS_Y, SLOT_A};
            5'd11:   m = '{OP_ACC_ANG,   AXIS_X, SLOT_B};
            5'd12:   m = '{OP_ADD_VEL,   AXIS_Y, SLOT_A};
            5'd13:   m = '{OP_ADD_AVEL,  AXIS_X, SLOT_B};
            5'd14:   m = '{OP_DAMP_VEL,  AXIS_Y, SLOT_A};
            5'd15:   m = '{OP_DAMP_AVEL, AXIS_X, SLOT_B};
            5'd16:   m = '{OP_ADD_POS,   AXIS_Y, SLOT_A};
            5'd17:   m = '{OP_ROT,       AXIS_X, SLOT_B};
            5'd18:   m = '{OP_ACC_ANG,   AXIS_Y, SLOT_A};
            5'd19:   m = '{OP_ACC_ANG,   AXIS_Z, SLOT_B};
            5'd20:   m = '{OP_ADD_AVEL,  AXIS_Y, SLOT_A};
            5'd21:   m = '{OP_ADD_AVEL,  AXIS_Z, SLOT_B};
            5'd22:   m = '{OP_DAMP_AVEL, AXIS_Y, SLOT_A};
            5'd23:   m = '{OP_DAMP_AVEL, AXIS_Z, SLOT_B};
            5'd24:   m = '{OP_ROT,       AXIS_Y, SLOT_A};
            5'd25:   m = '{OP_ROT,       AXIS_Z, SLOT_B};
            default: m = '{OP_CLAMP,     AXIS_NONE, SLOT_A};
        endcase
        return m;
    endfunction

endpackage

>>> rtl/rbe_motion_if.sv
// ----------------------------------------------------------------------------
// rbe_motion_if
// input channel: time step, force and torque word with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rbe_motion_if;
    logic               valid;
    logic               ready;
    logic [23:0]        dt;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;

    modport source (
        output valid, dt, force_x, force_y, force_z, torque_x, torque_y, torque_z,
        input  ready
    );

    modport sink (
        input  valid, dt, force_x, force_y, force_z, torque_x, torque_y, torque_z,
        output ready
    );
endinterface

>>> rtl/rbe_pose_if.sv
// ----------------------------------------------------------------------------
// rbe_pose_if
// output channel: position and rotation word with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rbe_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
        output ready
    );
endinterface

>>> rtl/rbe_cfg.sv
// ----------------------------------------------------------------------------
// rbe_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbe_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rbe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rbe_pkg::cfg_t                  cfg
);

    rbe_pkg::cfg_t cfg_reg;
    rbe_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rbe_pkg::REG_INV_MASS:    cfg_next.inv_mass       = cfg_data[30:0];
                rbe_pkg::REG_GRAVITY_Y:   cfg_next.gravity_y      = signed'(cfg_data);
                rbe_pkg::REG_GRAVITY_EN:  cfg_next.gravity_enable = cfg_data[0];
                rbe_pkg::REG_DAMPING:     cfg_next.damping        = cfg_data[16:0];
                rbe_pkg::REG_RADIUS:      cfg_next.radius         = cfg_data[28:0];
                rbe_pkg::REG_WORLD_SIZE:  cfg_next.world_size     = cfg_data[28:0];
                rbe_pkg::REG_INV_INERTIA: cfg_next.inv_inertia    = cfg_data[30:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_mass       <= rbe_pkg::INV_MASS_RST;
            cfg_reg.gravity_y      <= rbe_pkg::GRAVITY_Y_RST;
            cfg_reg.gravity_enable <= rbe_pkg::GRAVITY_EN_RST;
            cfg_reg.damping        <= rbe_pkg::DAMPING_RST;
            cfg_reg.radius         <= rbe_pkg::RADIUS_RST;
            cfg_reg.world_size     <= rbe_pkg::WORLD_SIZE_RST;
            cfg_reg.inv_inertia    <= rbe_pkg::INV_INERTIA_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/rbe_ctrl.sv
// ----------------------------------------------------------------------------
// rbe_ctrl
// sequencer: accepts a word, steps the micro-op list, loads the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rigid_body_euler_step_assert.svh"

module rbe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                motion_valid,
    output logic                motion_ready,
    output logic                pose_valid,
    input  logic                pose_ready,
    output rbe_pkg::ctrl_cmd_t  cmd
);

    rbe_pkg::ctrl_state_t            state_reg;
    rbe_pkg::ctrl_state_t            state_next;
    logic [rbe_pkg::STEP_W-1:0]      step_reg;
    logic [rbe_pkg::STEP_W-1:0]      step_next;
    logic                            pose_valid_reg;
    logic                            pose_valid_next;
    logic                            run_first;
    logic                            run_last;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        pose_valid_next = pose_valid_reg;
        cmd             = '0;
        motion_ready    = (state_reg == rbe_pkg::ST_IDLE);
        cmd.capture     = motion_valid && motion_ready;
        if (pose_valid_reg && pose_ready)
        begin
            pose_valid_next = 1'b0;
        end
        case (state_reg)
            rbe_pkg::ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = rbe_pkg::ST_RUN;
                    step_next  = '0;
                end
            end
            rbe_pkg::ST_RUN:
            begin
                cmd.issue = 1'b1;
                cmd.micro = rbe_pkg::seq_entry(step_reg);
                if (step_reg == rbe_pkg::LAST_STEP)
                begin
                    state_next = rbe_pkg::ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            rbe_pkg::ST_DRAIN:
            begin
                state_next = rbe_pkg::ST_DONE;
            end
            rbe_pkg::ST_DONE:
            begin
                if (!pose_valid_reg || pose_ready)
                begin
                    cmd.load_out    = 1'b1;
                    pose_valid_next = 1'b1;
                    state_next      = rbe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rbe_pkg::ST_IDLE;
            step_reg       <= '0;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pose_valid_reg <= pose_valid_next;
        end
    end

    assign pose_valid = pose_valid_reg;

    assign run_first = (state_reg == rbe_pkg::ST_RUN) && (step_reg == '0);
    assign run_last  = (state_reg == rbe_pkg::ST_RUN) && (step_reg == rbe_pkg::LAST_STEP);

    `RBE_ASSERT_NEXT(a_start_run, cmd.capture, run_first, "sequence not started at step zero")
    `RBE_ASSERT_IMPL(a_issue_range, cmd.issue, step_reg <= rbe_pkg::LAST_STEP, "issue past end")
    `RBE_ASSERT_NEXT(a_drain, run_last, state_reg == rbe_pkg::ST_DRAIN, "missing drain")
    `RBE_ASSERT_IMPL(a_load_free, cmd.load_out, !pose_valid_reg || pose_ready, "pose overwritten")

endmodule

>>> rtl/rbe_dp.sv
// ----------------------------------------------------------------------------
// rbe_dp
// datapath: shared 32x32 multiplier, saturating post stage, body state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbe_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rbe_pkg::cfg_t      cfg,
    input  rbe_pkg::ctrl_cmd_t cmd,
    input  rbe_pkg::motion_t   motion_word,
    output rbe_pkg::pose_t     pose_word
);

    localparam logic signed [63:0] ROT_LIMIT = 64'sd360 <<< FRAC_BITS;
    localparam logic signed [31:0] S32_MAX   = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN   = 32'sh80000000;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v[63:31] == '0 || v[63:31] == '1)
            return v[31:0];
        else if (v[63])
            return S32_MIN;
        else
            return S32_MAX;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] == s[31])
            return s[31:0];
        else if (s[32])
            return S32_MIN;
        else
            return S32_MAX;
    endfunction

    rbe_pkg::motion_t   in_reg;
    logic signed [31:0] vel_reg  [0:2];
    logic signed [31:0] pos_reg  [0:2];
    logic signed [31:0] avel_reg [0:2];
    logic signed [31:0] rot_reg  [0:2];
    logic signed [31:0] vel_next  [0:2];
    logic signed [31:0] pos_next  [0:2];
    logic signed [31:0] avel_next [0:2];
    logic signed [31:0] rot_next  [0:2];
    logic signed [31:0] tmp_reg  [0:1];
    logic signed [31:0] tmp_next [0:1];

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic               post_valid_reg;
    rbe_pkg::micro_t    post_micro_reg;
    rbe_pkg::pose_t     pose_reg;

    logic signed [31:0] a_op;
    logic [30:0]        b_op;
    logic signed [31:0] b_ext;
    logic               issue_axis_ok;
    rbe_pkg::micro_t    im;

    logic signed [63:0] shifted;
    logic signed [31:0] mul_sat;
    logic signed [31:0] acc;
    logic signed [31:0] rot_sum;
    logic signed [33:0] cv;
    logic signed [33:0] clamp_lo;
    logic signed [33:0] clamp_hi;
    logic               post_axis_ok;
    logic [1:0]         ax;

    assign clamp_lo = signed'(34'(cfg.radius));
    assign clamp_hi = signed'(34'(cfg.world_size)) - signed'(34'({cfg.radius, 1'b0}));

    // issue stage: operand select and multiply
    always_comb
    begin
        im            = cmd.micro;
        issue_axis_ok = (im.axis <= rbe_pkg::AXIS_Z);
        a_op          = '0;
        b_op          = '0;
        if (issue_axis_ok)
        begin
            case (im.op)
                rbe_pkg::OP_ACC_LIN:
                begin
                    case (im.axis)
                        rbe_pkg::AXIS_X: a_op = in_reg.force_x;
                        rbe_pkg::AXIS_Y: a_op = in_reg.force_y;
                        default:         a_op = in_reg.force_z;
                    endcase
                    b_op = cfg.inv_mass;
                end
                rbe_pkg::OP_ACC_ANG:
                begin
                    case (im.axis)
                        rbe_pkg::AXIS_X: a_op = in_reg.torque_x;
                        rbe_pkg::AXIS_Y: a_op = in_reg.torque_y;
                        default:         a_op = in_reg.torque_z;
                    endcase
                    b_op = cfg.inv_inertia;
                end
                rbe_pkg::OP_ADD_VEL, rbe_pkg::OP_ADD_AVEL:
                begin
                    a_op = tmp_reg[im.slot];
                    b_op = 31'(in_reg.dt);
                end
                rbe_pkg::OP_DAMP_VEL:
                begin
                    a_op = vel_reg[im.axis];
                    b_op = 31'(cfg.damping);
                end
                rbe_pkg::OP_ADD_POS:
                begin
                    a_op = vel_reg[im.axis];
                    b_op = 31'(in_reg.dt);
                end
                rbe_pkg::OP_DAMP_AVEL:
                begin
                    a_op = avel_reg[im.axis];
                    b_op = 31'(cfg.damping);
                end
                default:
                begin
                    a_op = '0;
                    b_op = '0;
                end
            endcase
        end
        b_ext     = signed'({1'b0, b_op});
        prod_next = a_op * b_ext;
    end

    // post stage: floor shift, saturate, then accumulate, overwrite, clamp or wrap into state
    always_comb
    begin
        shifted      = prod_reg >>> FRAC_BITS;
        mul_sat      = sat64(shifted);
        ax           = post_micro_reg.axis;
        post_axis_ok = (ax <= rbe_pkg::AXIS_Z);
        vel_next     = vel_reg;
        pos_next     = pos_reg;
        avel_next    = avel_reg;
        rot_next     = rot_reg;
        tmp_next     = tmp_reg;
        acc          = mul_sat;
        rot_sum      = '0;
        cv           = '0;
        if (post_valid_reg && post_axis_ok)
        begin
            case (post_micro_reg.op)
                rbe_pkg::OP_ACC_LIN:
                begin
                    if (ax == rbe_pkg::AXIS_Y && cfg.gravity_enable)
                    begin
                        acc = add_sat(mul_sat, cfg.gravity_y);
                    end
                    tmp_next[post_micro_reg.slot] = acc;
                end
                rbe_pkg::OP_ADD_VEL:
                begin
                    vel_next[ax] = add_sat(vel_reg[ax], mul_sat);
                end
                rbe_pkg::OP_DAMP_VEL:
                begin
                    vel_next[ax] = mul_sat;
                end
                rbe_pkg::OP_ADD_POS:
                begin
                    pos_next[ax] = add_sat(pos_reg[ax], mul_sat);
                end
                rbe_pkg::OP_CLAMP:
                begin
                    // low bound first, high bound wins on an empty range
                    cv = 34'(pos_reg[ax]);
                    if (cv < clamp_lo)
                    begin
                        cv = clamp_lo;
                    end
                    if (cv > clamp_hi)
                    begin
                        cv = clamp_hi;
                    end
                    pos_next[ax] = cv[31:0];
                end
                rbe_pkg::OP_ACC_ANG:
                begin
                    tmp_next[post_micro_reg.slot] = mul_sat;
                end
                rbe_pkg::OP_ADD_AVEL:
                begin
                    avel_next[ax] = add_sat(avel_reg[ax], mul_sat);
                end
                rbe_pkg::OP_DAMP_AVEL:
                begin
                    avel_next[ax] = mul_sat;
                end
                rbe_pkg::OP_ROT:
                begin
                    rot_sum = add_sat(rot_reg[ax], avel_reg[ax]);
                    if (64'(rot_sum) > ROT_LIMIT)
                    begin
                        rot_sum = rot_sum - ROT_LIMIT[31:0];
                    end
                    rot_next[ax] = rot_sum;
                end
                default:
                begin
                    tmp_next = tmp_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg        <= '{default: '0};
            pos_reg        <= '{default: '0};
            avel_reg       <= '{default: '0};
            rot_reg        <= '{default: '0};
            post_valid_reg <= 1'b0;
        end
        else
        begin
            vel_reg        <= vel_next;
            pos_reg        <= pos_next;
            avel_reg       <= avel_next;
            rot_reg        <= rot_next;
            post_valid_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg        <= tmp_next;
        prod_reg       <= prod_next;
        post_micro_reg <= cmd.micro;
        if (cmd.capture)
        begin
            in_reg <= motion_word;
        end
        if (cmd.load_out)
        begin
            pose_reg.pos_x <= pos_reg[0];
            pose_reg.pos_y <= pos_reg[1];
            pose_reg.pos_z <= pos_reg[2];
            pose_reg.rot_x <= rot_reg[0];
            pose_reg.rot_y <= rot_reg[1];
            pose_reg.rot_z <= rot_reg[2];
        end
    end

    assign pose_word = pose_reg;

endmodule

>>> rtl/rigid_body_euler_step.sv
// ----------------------------------------------------------------------------
// rigid_body_euler_step
// semi-implicit euler step of one rigid body per input word, signed fixed point
//
//   channel  dir  handshake        payload
//   motion   in   valid / ready    dt, force_x/y/z, torque_x/y/z
//   pose     out  valid / ready    pos_x/y/z, rot_x/y/z
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// a new word is accepted only in idle, after the previous result is loaded
// the 26 micro-ops go through the one shared 32x32 multiplier in turn,
// followed by a drain state and an output load state
// rst_n clears body state to zero and registers to their defaults
// a waiting result does not block the next accept; only the load waits for pose
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rigid_body_euler_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rbe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    rbe_motion_if.sink                      motion,
    rbe_pose_if.source                      pose
);

    rbe_pkg::cfg_t      cfg;
    rbe_pkg::ctrl_cmd_t cmd;
    rbe_pkg::motion_t   motion_word;
    rbe_pkg::pose_t     pose_word;

    assign motion_word.dt       = motion.dt;
    assign motion_word.force_x  = motion.force_x;
    assign motion_word.force_y  = motion.force_y;
    assign motion_word.force_z  = motion.force_z;
    assign motion_word.torque_x = motion.torque_x;
    assign motion_word.torque_y = motion.torque_y;
    assign motion_word.torque_z = motion.torque_z;

    assign pose.pos_x = pose_word.pos_x;
    assign pose.pos_y = pose_word.pos_y;
    assign pose.pos_z = pose_word.pos_z;
    assign pose.rot_x = pose_word.rot_x;
    assign pose.rot_y = pose_word.rot_y;
    assign pose.rot_z = pose_word.rot_z;

    rbe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rbe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .motion_valid (motion.valid),
        .motion_ready (motion.ready),
        .pose_valid   (pose.valid),
        .pose_ready   (pose.ready),
        .cmd          (cmd)
    );

    rbe_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .motion_word (motion_word),
        .pose_word   (pose_word)
    );

endmodule
